>>> hdl/plf_pkg.sv
// Shared types, codes and letter helpers for the Playfair digraph encryptor.
package plf_pkg;

  localparam int unsigned Cells   = 25;
  localparam int unsigned Letters = 26;
  localparam int unsigned CellAw  = $clog2(Cells);
  localparam int unsigned LetAw   = $clog2(Letters);

  localparam logic [LetAw-1:0] IdxI = LetAw'(8);
  localparam logic [LetAw-1:0] IdxJ = LetAw'(9);
  localparam logic [LetAw-1:0] IdxX = LetAw'(23);
  localparam logic [LetAw-1:0] IdxLast = LetAw'(Letters - 1);

  localparam logic [6:0] AsciiA = 7'd65;

  typedef enum logic [1:0] {
    ACT_CLEAR    = 2'd0,
    ACT_KEY      = 2'd1,
    ACT_COMPLETE = 2'd2,
    ACT_ENCRYPT  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_NOT_READY = 2'd2
  } status_e;

  typedef struct packed {
    logic             valid;
    logic [LetAw-1:0] idx;
  } letter_t;

  typedef struct packed {
    logic [CellAw-1:0] first;
    logic [CellAw-1:0] second;
  } cell_pair_t;

  // Maps a raw byte to a letter index with lower case folded to upper and J to I.
  function automatic letter_t letter_index(input logic [7:0] c);
    letter_t r;
    r.valid = 1'b1;
    r.idx   = '0;
    if (c >= 8'd65 && c <= 8'd90) begin
      r.idx = LetAw'(c - 8'd65);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      r.idx = LetAw'(c - 8'd97);
    end else begin
      r.valid = 1'b0;
    end
    if (r.idx == IdxJ) begin
      r.idx = IdxI;
    end
    return r;
  endfunction

endpackage

>>> hdl/plf_ram.sv
// Simple one-write, one-read memory with a registered read port.
module plf_ram #(
  parameter int unsigned Depth = 25,
  parameter int unsigned Width = 5
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/plf_addr_unit.sv
// Turns two letter positions into the two cell addresses of the cipher letters.
module plf_addr_unit (
  input  logic [plf_pkg::CellAw-1:0] pos_a_i,
  input  logic [plf_pkg::CellAw-1:0] pos_b_i,
  output plf_pkg::cell_pair_t        cells_o
);
  import plf_pkg::*;

  function automatic logic [2:0] row_of(input logic [CellAw-1:0] p);
    logic [2:0] r;
    if (p >= CellAw'(20)) begin
      r = 3'd4;
    end else if (p >= CellAw'(15)) begin
      r = 3'd3;
    end else if (p >= CellAw'(10)) begin
      r = 3'd2;
    end else if (p >= CellAw'(5)) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == 3'd4) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [CellAw-1:0] addr_of(input logic [2:0] r, input logic [2:0] c);
    return CellAw'({2'b00, r} * 5'd5 + {2'b00, c});
  endfunction

  logic [2:0] r1, c1, r2, c2;

  always_comb begin
    r1 = row_of(pos_a_i);
    r2 = row_of(pos_b_i);
    c1 = 3'(pos_a_i - CellAw'({2'b00, r1} * 5'd5));
    c2 = 3'(pos_b_i - CellAw'({2'b00, r2} * 5'd5));
    priority if (r1 == r2) begin
      cells_o.first  = addr_of(r1, wrap_inc(c1));
      cells_o.second = addr_of(r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      cells_o.first  = addr_of(wrap_inc(r1), c1);
      cells_o.second = addr_of(wrap_inc(r2), c2);
    end else begin
      cells_o.first  = addr_of(r1, c2);
      cells_o.second = addr_of(r2, c1);
    end
  end

endmodule

>>> hdl/playfair_digraph_encryptor.sv
// Top level of the Playfair digraph encryptor: sequencer, key state and result register.
// Clear and key-letter requests complete at acceptance and leave busy_o low. A complete
// request holds busy_o while it steps through the letter codes, one letter code a cycle.
// An encrypt request holds busy_o through PosA, PosB, Addr, Cell2 and Out (two position reads,
// two cell reads, one read port per store); valid_o rises as busy_o falls. A failing encrypt
// answers in the next cycle. Reset clears all control state. The receiver cannot stall results.
module playfair_digraph_encryptor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] action_i,
  input  logic [7:0] first_char_i,
  input  logic [7:0] second_char_i,
  input  logic       has_second_i,
  output logic       valid_o,
  output logic [6:0] cipher_first_o,
  output logic [6:0] cipher_second_o,
  output logic [1:0] status_o
);
  import plf_pkg::*;

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StFill  = 3'd1;
  localparam logic [2:0] StPosA  = 3'd2;
  localparam logic [2:0] StPosB  = 3'd3;
  localparam logic [2:0] StAddr  = 3'd4;
  localparam logic [2:0] StCell2 = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [Letters-1:0] seen_q, seen_d;
  logic [CellAw-1:0]  fill_q, fill_d;
  logic               ready_q, ready_d;
  logic [LetAw-1:0]   cnt_q, cnt_d;

  // Held letters of the pair being encrypted and intermediate results.
  logic [LetAw-1:0]  a_q, a_d, b_q, b_d;
  logic [CellAw-1:0] pa_q, pa_d, o2addr_q, o2addr_d;
  logic [LetAw-1:0]  o1_q, o1_d;

  logic       valid_q, valid_d;
  logic [6:0] first_q, first_d, second_q, second_d;
  logic [1:0] status_q, status_d;

  letter_t    let_a, let_b;
  logic       accept;

  // Memory ports.
  logic              cell_we, pos_we;
  logic [CellAw-1:0] cell_waddr, cell_raddr, cell_rdata_pos;
  logic [LetAw-1:0]  cell_wdata, cell_rdata;
  logic [LetAw-1:0]  pos_waddr, pos_raddr;
  logic [CellAw-1:0] pos_wdata, pos_rdata;
  logic [LetAw-1:0]  place_idx;
  logic              place_en;

  cell_pair_t        pair_addr;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != StIdle);

  assign let_a = letter_index(first_char_i);
  always_comb begin
    if (has_second_i) begin
      let_b = letter_index(second_char_i);
    end else begin
      let_b.valid = 1'b1;
      let_b.idx   = IdxX;
    end
  end

  // Cell number -> letter code store and letter code -> cell number store.
  plf_ram #(.Depth(Cells), .Width(LetAw)) u_cells (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  plf_ram #(.Depth(Letters), .Width(CellAw)) u_pos (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  // The pair geometry is resolved once both positions are known.
  assign cell_rdata_pos = pos_rdata;
  plf_addr_unit u_addr (
    .pos_a_i (pa_q),
    .pos_b_i (cell_rdata_pos),
    .cells_o (pair_addr)
  );

  // Placing a letter writes both stores at once, guarded by seen bit and free space.
  always_comb begin
    place_en = 1'b0;
    place_idx = let_a.idx;
    if (state_q == StFill) begin
      place_idx = cnt_q;
      place_en  = (cnt_q != IdxJ);
    end else if (accept && action_e'(action_i) == ACT_KEY) begin
      place_en = let_a.valid;
    end
  end

  logic do_place;
  assign do_place = place_en && !seen_q[place_idx] && (fill_q < CellAw'(Cells));

  assign cell_we    = do_place;
  assign cell_waddr = fill_q;
  assign cell_wdata = place_idx;
  assign pos_we     = do_place;
  assign pos_waddr  = place_idx;
  assign pos_wdata  = fill_q;

  assign pos_raddr  = (state_q == StPosA) ? a_q : b_q;
  assign cell_raddr = (state_q == StAddr) ? pair_addr.first : o2addr_q;

  always_comb begin
    state_d  = state_q;
    seen_d   = seen_q;
    fill_d   = fill_q;
    ready_d  = ready_q;
    cnt_d    = cnt_q;
    a_d      = a_q;
    b_d      = b_q;
    pa_d     = pa_q;
    o2addr_d = o2addr_q;
    o1_d     = o1_q;
    valid_d  = 1'b0;
    first_d  = first_q;
    second_d = second_q;
    status_d = status_q;

    if (do_place) begin
      seen_d[place_idx] = 1'b1;
      fill_d            = fill_q + CellAw'(1);
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (action_e'(action_i))
            ACT_CLEAR: begin
              seen_d  = '0;
              fill_d  = '0;
              ready_d = 1'b0;
            end
            ACT_KEY: begin
              // Placement is handled by the shared write path above.
            end
            ACT_COMPLETE: begin
              cnt_d   = '0;
              state_d = StFill;
            end
            ACT_ENCRYPT: begin
              a_d = let_a.idx;
              b_d = let_b.idx;
              if (!ready_q) begin
                valid_d  = 1'b1;
                first_d  = '0;
                second_d = '0;
                status_d = STATUS_NOT_READY;
              end else if (!let_a.valid || !let_b.valid) begin
                valid_d  = 1'b1;
                first_d  = '0;
                second_d = '0;
                status_d = STATUS_NOT_FOUND;
              end else begin
                state_d = StPosA;
              end
            end
            default: ;
          endcase
        end
      end
      StFill: begin
        if (cnt_q == IdxLast) begin
          ready_d = 1'b1;
          state_d = StIdle;
        end else begin
          cnt_d = cnt_q + LetAw'(1);
        end
      end
      StPosA: begin
        state_d = StPosB;
      end
      StPosB: begin
        pa_d    = pos_rdata;
        state_d = StAddr;
      end
      StAddr: begin
        o2addr_d = pair_addr.second;
        state_d  = StCell2;
      end
      StCell2: begin
        o1_d    = cell_rdata;
        state_d = StOut;
      end
      StOut: begin
        valid_d  = 1'b1;
        first_d  = AsciiA + 7'(o1_q);
        second_d = AsciiA + 7'(cell_rdata);
        status_d = STATUS_OK;
        state_d  = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      seen_q  <= '0;
      fill_q  <= '0;
      ready_q <= 1'b0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      fill_q  <= fill_d;
      ready_q <= ready_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    pa_q     <= pa_d;
    o2addr_q <= o2addr_d;
    o1_q     <= o1_d;
    first_q  <= first_d;
    second_q <= second_d;
    status_q <= status_d;
  end

  assign valid_o         = valid_q;
  assign cipher_first_o  = first_q;
  assign cipher_second_o = second_q;
  assign status_o        = status_q;

endmodule
